### design/aes_pkg.sv
// Package with the AES-128 types, S-box and round helper functions.
`default_nettype none
package aes_pkg;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_req_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_req_t;

  localparam int unsigned NumRounds = 10;

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;

  localparam logic [7:0] ReducePoly = 8'h1B;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
    8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
    8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
    8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
    8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
    8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
    8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
    8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
    8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
    8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
    8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
    8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Byte n of a block sits in bits 127-8n downto 120-8n.
  function automatic logic [7:0] get_byte(logic [127:0] blk, int n);
    return blk[127 - 8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? ReducePoly : 8'h00);
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4)*4 + r)];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4 + 1);
      a2 = get_byte(s, c*4 + 2);
      a3 = get_byte(s, c*4 + 3);
      b0 = xtime(a0);
      b1 = xtime(a1);
      b2 = xtime(a2);
      b3 = xtime(a3);
      t[127 - 32*c -: 32] = {b0 ^ b1 ^ a1 ^ a2 ^ a3, a0 ^ b1 ^ b2 ^ a2 ^ a3,
                             a0 ^ a1 ^ b2 ^ b3 ^ a3, b0 ^ a0 ^ a1 ^ a2 ^ b3};
    end
    return t;
  endfunction

  // One step of the key schedule: four new words from the previous four.
  function automatic logic [127:0] next_round_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tw;
    tw = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ tw;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

### design/aes_round.sv
// One registered AES round stage with its own round-key expansion step.
`default_nettype none
module aes_round #(
  parameter logic [7:0] RoundConst = 8'h01,
  parameter bit         LastRound  = 1'b0
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         vld_in,
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] key_in,
  output logic              vld_out,
  output logic [127:0]      state_out,
  output logic [127:0]      key_out
);

  logic         vld_r;
  logic [127:0] state_r, state_nxt;
  logic [127:0] key_r, key_nxt;

  always_comb begin
    key_nxt = aes_pkg::next_round_key(key_in, RoundConst);
    if (LastRound) begin
      state_nxt = aes_pkg::sub_shift(state_in) ^ key_nxt;
    end else begin
      state_nxt = aes_pkg::mix_cols(aes_pkg::sub_shift(state_in)) ^ key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    state_r <= state_nxt;
    key_r   <= key_nxt;
  end

  assign vld_out   = vld_r;
  assign state_out = state_r;
  assign key_out   = key_r;

endmodule
`default_nettype wire

### design/aes128_block_encrypt.sv
// Top level of the pipelined AES-128 block encryption core.
//
// Usage: write key_high (index 0) and key_low (index 1) through the cfg_
// port while no block is in flight. A block is taken at each edge where
// start is high and busy is low; busy is always low, so a new block may
// enter every cycle. The block goes through an input stage holding the
// initial AddRoundKey, then ten round stages, each with its own key
// expansion step carried beside the data. The ciphertext appears on
// out_data with out_valid high for exactly one cycle once the block has
// left the last round stage, and is accepted at the edge ending that cycle.
// Throughput is one block per cycle, since every one of the eleven stages
// takes a new block each cycle. Reset clears the valid bits and sets the
// key to zero. The receiver cannot stall; results must be taken when shown.
`default_nettype none
module aes128_block_encrypt (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire aes_pkg::in_req_t in_data,
  output logic                 out_valid,
  output aes_pkg::out_req_t    out_data,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [63:0]     cfg_wdata
);

  localparam int unsigned NR = aes_pkg::NumRounds;

  logic [63:0]  key_high_r, key_low_r;
  logic         vld0_r;
  logic [127:0] state0_r, key0_r;

  logic         vld   [NR+1];
  logic [127:0] state [NR+1];
  logic [127:0] rkey  [NR+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      vld0_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          aes_pkg::CfgKeyHigh: key_high_r <= cfg_wdata;
          aes_pkg::CfgKeyLow:  key_low_r  <= cfg_wdata;
          default: ;
        endcase
      end
      vld0_r <= start && !busy;
    end
    state0_r <= {in_data.plain_high, in_data.plain_low} ^ {key_high_r, key_low_r};
    key0_r   <= {key_high_r, key_low_r};
  end

  assign vld[0]   = vld0_r;
  assign state[0] = state0_r;
  assign rkey[0]  = key0_r;

  for (genvar g = 0; g < NR; g++) begin : g_round
    aes_round #(
      .RoundConst(aes_pkg::RCON[g]),
      .LastRound (g == NR - 1)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .vld_in   (vld[g]),
      .state_in (state[g]),
      .key_in   (rkey[g]),
      .vld_out  (vld[g+1]),
      .state_out(state[g+1]),
      .key_out  (rkey[g+1])
    );
  end

  assign out_valid            = vld[NR];
  assign out_data.cipher_high = state[NR][127:64];
  assign out_data.cipher_low  = state[NR][63:0];

  // Every request is answered on out_valid after the input stage and all round stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##11 out_valid) else $error("result missing after request");
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld[NR-1]))
    else $error("result without a request in the last stage");
  a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
    vld0_r |-> $past(start)) else $error("first stage valid without request");

endmodule
`default_nettype wire
